/* src/pcc_pkg.sv */
// Shared types and constants of the Pearson correlation block.
// Depends on nothing; every other file takes names from it by scope.
`default_nettype none
package pcc_pkg;

   localparam int IN_BITS   = 16;   // width of a sample field on the port
   localparam int LIN_BITS  = 24;   // running sums of samples
   localparam int SQ_BITS   = 40;   // running sums of products and squares
   localparam int CNT_BITS  = 13;   // pair count, holds up to 8191
   localparam int PROD_BITS = 48;   // product of two 24-bit values
   localparam int NUM_BITS  = SQ_BITS + CNT_BITS + 1;  // numerator and variances
   localparam int FRAC_BITS = 15;   // Q1.15 fraction bits
   localparam int CORR_BITS = 16;
   localparam int Q_DEPTH   = 4;    // finished vectors waiting for the back end
   localparam int QP_BITS   = 2;
   localparam int QC_BITS   = 3;

   localparam logic signed [CORR_BITS-1:0] CORR_MAX = 16'sh7FFF;
   localparam logic signed [CORR_BITS-1:0] CORR_MIN = 16'sh8000;

   // sums of one finished vector
   typedef struct packed {
      logic [CNT_BITS-1:0]        n;
      logic signed [LIN_BITS-1:0] sx;
      logic signed [LIN_BITS-1:0] sy;
      logic signed [SQ_BITS-1:0]  sxy;
      logic signed [SQ_BITS-1:0]  sxx;
      logic signed [SQ_BITS-1:0]  syy;
      logic                       ovf;
   } snap_type;

   typedef struct packed {
      logic [QC_BITS-1:0] count;
      logic               empty;
      logic               full;
   } qstat_type;

endpackage
`default_nettype wire

/* src/pcc_channels.sv */
// Valid/ready channel interfaces: sample pairs in, coefficients out.
// Depends on pcc_pkg for field widths.
`default_nettype none
interface pcc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcc_pkg::IN_BITS-1:0]   sample_x;
   logic signed [pcc_pkg::IN_BITS-1:0]   sample_y;
   logic                                 last;
   modport source (output valid, sample_x, sample_y, last, input ready);
   modport sink   (input valid, sample_x, sample_y, last, output ready);
endinterface

interface pcc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcc_pkg::CORR_BITS-1:0] correlation;
   logic                                 zero_variance;
   logic                                 count_overflow;
   modport source (output valid, correlation, zero_variance, count_overflow, input ready);
   modport sink   (input valid, correlation, zero_variance, count_overflow, output ready);
endinterface
`default_nettype wire

/* src/pearson_correlation.sv */
// Top level of the streaming Pearson correlation block.
// Depends on pcc_pkg, pcc_channels, pcc_front, pcc_queue and pcc_back.
`default_nettype none
// Sample pairs enter on req_chan at one word per cycle while ready is
// high; sample_x and sample_y are read as SAMPLE_BITS-bit two's complement
// values. Each accepted pair passes a three-stage multiply-accumulate
// pipeline that keeps the count and the sums of x, y, xy, xx and yy; pairs
// beyond MAX_SAMPLES are not summed and set count_overflow on the result.
// The word marked last closes the vector: its sums go into a four-entry
// queue and the accumulators start over, so the next vector streams in at
// full rate. A sequential back end then produces one rsp_chan word per
// vector, in these steps from pop to handshake: the pop, a shared 24x24
// multiplier for the products of sums, a shift-add count multiply, the
// variances, a shift-add for the product of the variances, a
// digit-by-digit square root, a restoring divide for the 15 quotient
// bits and the output. Zero variance and clamped results leave early.
// The front end stalls only when four finished vectors sit in the queue
// or in the accumulator pipeline ahead of it.
module pearson_correlation #(
   parameter int MAX_SAMPLES = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   pcc_req_if.sink    req_chan,
   pcc_rsp_if.source  rsp_chan
);
   pcc_pkg::qstat_type q_stat;
   pcc_pkg::snap_type  push_data, head;
   logic               push, pop;

   // accumulate and hand off finished vectors
   pcc_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset), .req(req_chan), .q_stat(q_stat),
      .push(push), .push_data(push_data)
   );

   // hold vectors between the two sides
   pcc_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .head(head), .stat(q_stat)
   );

   // root, divide and clamp
   pcc_back u_back (
      .clock(clock), .reset(reset), .head(head), .q_stat(q_stat),
      .pop(pop), .rsp(rsp_chan)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_stat.full || pop)) else $error("queue overrun");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= pcc_pkg::QC_BITS'(pcc_pkg::Q_DEPTH)) else $error("queue count");
   a_zero_corr: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.zero_variance) |-> rsp_chan.correlation == '0)
      else $error("zero variance with nonzero coefficient");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("pop from empty queue");
endmodule
`default_nettype wire

/* src/pcc_front.sv */
// Front end: accepts sample pairs, counts them and runs the accumulators.
// Depends on pcc_pkg and pcc_channels; pushes finished sums to pcc_queue.
`default_nettype none
module pcc_front #(
   parameter int MAX_SAMPLES = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   pcc_req_if.sink           req,
   input  pcc_pkg::qstat_type q_stat,
   output logic              push,
   output pcc_pkg::snap_type push_data
);
   localparam int SH = pcc_pkg::LIN_BITS - SAMPLE_BITS;

   logic [pcc_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;

   logic s1_valid_ff, s1_take_ff, s1_last_ff, s1_ovf_ff;
   logic [pcc_pkg::CNT_BITS-1:0] s1_n_ff;
   logic signed [pcc_pkg::LIN_BITS-1:0] s1_x_ff, s1_y_ff;

   logic s2_valid_ff, s2_take_ff, s2_last_ff, s2_ovf_ff;
   logic [pcc_pkg::CNT_BITS-1:0] s2_n_ff;
   logic signed [pcc_pkg::LIN_BITS-1:0] s2_x_ff, s2_y_ff;
   logic signed [pcc_pkg::PROD_BITS-1:0] s2_xy_ff, s2_xx_ff, s2_yy_ff;

   logic signed [pcc_pkg::LIN_BITS-1:0] sx_ff, sy_ff, sx_in, sy_in;
   logic signed [pcc_pkg::SQ_BITS-1:0] sxy_ff, sxx_ff, syy_ff, sxy_in, sxx_in, syy_in;

   logic accept, take;
   logic [pcc_pkg::CNT_BITS-1:0] cnt_next;
   logic [pcc_pkg::LIN_BITS-1:0] xw, yw;
   logic signed [pcc_pkg::LIN_BITS-1:0] xt, yt, xs, ys;
   logic [pcc_pkg::QC_BITS-1:0] pending;

   // reserve queue room for every last word still in the pipeline
   assign pending = q_stat.count + pcc_pkg::QC_BITS'(s1_valid_ff && s1_last_ff)
                    + pcc_pkg::QC_BITS'(s2_valid_ff && s2_last_ff);
   assign req.ready = pending < pcc_pkg::QC_BITS'(pcc_pkg::Q_DEPTH);
   assign accept = req.valid && req.ready;

   // read the port as a SAMPLE_BITS-wide two's complement value
   assign xw = pcc_pkg::LIN_BITS'(unsigned'(req.sample_x));
   assign yw = pcc_pkg::LIN_BITS'(unsigned'(req.sample_y));
   assign xt = signed'(xw << SH);
   assign yt = signed'(yw << SH);
   assign xs = xt >>> SH;
   assign ys = yt >>> SH;

   assign take = count_ff < pcc_pkg::CNT_BITS'(MAX_SAMPLES);
   assign cnt_next = take ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         count_in = req.last ? '0 : cnt_next;
         ovf_in = req.last ? 1'b0 : (ovf_ff || !take);
      end
   end

   always_comb begin
      sx_in = sx_ff;
      sy_in = sy_ff;
      sxy_in = sxy_ff;
      sxx_in = sxx_ff;
      syy_in = syy_ff;
      if (s2_valid_ff && s2_take_ff) begin
         sx_in = sx_ff + s2_x_ff;
         sy_in = sy_ff + s2_y_ff;
         sxy_in = sxy_ff + s2_xy_ff[pcc_pkg::SQ_BITS-1:0];
         sxx_in = sxx_ff + s2_xx_ff[pcc_pkg::SQ_BITS-1:0];
         syy_in = syy_ff + s2_yy_ff[pcc_pkg::SQ_BITS-1:0];
      end
   end

   assign push = s2_valid_ff && s2_last_ff;
   assign push_data = '{n: s2_n_ff, sx: sx_in, sy: sy_in, sxy: sxy_in, sxx: sxx_in,
                        syy: syy_in, ovf: s2_ovf_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sx_ff <= '0;
         sy_ff <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         // drop the sums once a vector is handed off
         if (push) begin
            sx_ff <= '0;
            sy_ff <= '0;
            sxy_ff <= '0;
            sxx_ff <= '0;
            syy_ff <= '0;
         end else begin
            sx_ff <= sx_in;
            sy_ff <= sy_in;
            sxy_ff <= sxy_in;
            sxx_ff <= sxx_in;
            syy_ff <= syy_in;
         end
      end
      s1_take_ff <= take;
      s1_last_ff <= req.last;
      s1_n_ff <= cnt_next;
      s1_ovf_ff <= ovf_ff || !take;
      s1_x_ff <= xs;
      s1_y_ff <= ys;
      s2_take_ff <= s1_take_ff;
      s2_last_ff <= s1_last_ff;
      s2_n_ff <= s1_n_ff;
      s2_ovf_ff <= s1_ovf_ff;
      s2_x_ff <= s1_x_ff;
      s2_y_ff <= s1_y_ff;
      s2_xy_ff <= s1_x_ff * s1_y_ff;
      s2_xx_ff <= s1_x_ff * s1_x_ff;
      s2_yy_ff <= s1_y_ff * s1_y_ff;
   end
endmodule
`default_nettype wire

/* src/pcc_queue.sv */
// Short queue of finished sums between front and back end.
// Depends on pcc_pkg.
`default_nettype none
module pcc_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  pcc_pkg::snap_type  push_data,
   input  wire                pop,
   output pcc_pkg::snap_type  head,
   output pcc_pkg::qstat_type stat
);
   pcc_pkg::snap_type entry_ff [pcc_pkg::Q_DEPTH];
   logic [pcc_pkg::QP_BITS-1:0] wr_ff, rd_ff;
   logic [pcc_pkg::QC_BITS-1:0] count_ff, count_in;

   assign head = entry_ff[rd_ff];
   assign stat = '{count: count_ff, empty: count_ff == '0,
                   full: count_ff == pcc_pkg::QC_BITS'(pcc_pkg::Q_DEPTH)};

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
      end
      if (push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

/* src/pcc_back.sv */
// Back end: forms numerator and variances, takes the root of their product
// and divides, one step a cycle. Depends on pcc_pkg and pcc_channels.
`default_nettype none
module pcc_back (
   input  wire                clock,
   input  wire                reset,
   input  pcc_pkg::snap_type  head,
   input  pcc_pkg::qstat_type q_stat,
   output logic               pop,
   pcc_rsp_if.source          rsp
);
   localparam int NW = pcc_pkg::NUM_BITS;
   localparam int PW = 2 * NW;
   localparam int RW = NW + 3;
   localparam int CW = 6;

   typedef enum logic [2:0] {
      IDLE, PROD, NMUL, VARS, VMUL, SQRT, DIVIDE, DONE
   } state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff;
   pcc_pkg::snap_type ent_ff;
   logic signed [pcc_pkg::PROD_BITS-1:0] pxy_ff, pxx_ff, pyy_ff, mul_p;
   logic signed [pcc_pkg::LIN_BITS-1:0] mul_a, mul_b;
   logic signed [NW-1:0] axy_ff, axx_ff, ayy_ff, mxy_ff, mxx_ff, myy_ff;
   logic [pcc_pkg::CNT_BITS-1:0] nsh_ff;
   logic signed [NW-1:0] num_ff, num_c, vx_c, vy_c;
   logic [NW-1:0] b_ff, root_ff, mag;
   logic [PW-1:0] acc_ff, sh_ff;
   logic [RW-1:0] rem_ff, r2, trial, d2;
   logic [pcc_pkg::FRAC_BITS-1:0] q_ff;
   logic valid_ff, zero_ff, ovf_ff;
   logic signed [pcc_pkg::CORR_BITS-1:0] corr_ff;

   assign pop = (state_ff == IDLE) && !q_stat.empty;
   assign rsp.valid = valid_ff;
   assign rsp.correlation = corr_ff;
   assign rsp.zero_variance = zero_ff;
   assign rsp.count_overflow = ovf_ff;

   // one shared multiplier for the three products of sums
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin mul_a = ent_ff.sx; mul_b = ent_ff.sy; end
         2'd1: begin mul_a = ent_ff.sx; mul_b = ent_ff.sx; end
         default: begin mul_a = ent_ff.sy; mul_b = ent_ff.sy; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign num_c = axy_ff - NW'(pxy_ff);
   assign vx_c = axx_ff - NW'(pxx_ff);
   assign vy_c = ayy_ff - NW'(pyy_ff);
   assign mag = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);

   assign r2 = {rem_ff[RW-3:0], sh_ff[PW-1:PW-2]};
   assign trial = RW'({root_ff, 2'b01});
   assign d2 = {rem_ff[RW-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (!q_stat.empty) begin
                  ent_ff <= head;
                  cnt_ff <= '0;
                  state_ff <= PROD;
               end
            end
            PROD: begin
               case (cnt_ff[1:0])
                  2'd0: pxy_ff <= mul_p;
                  2'd1: pxx_ff <= mul_p;
                  default: pyy_ff <= mul_p;
               endcase
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(2)) begin
                  cnt_ff <= '0;
                  axy_ff <= '0;
                  axx_ff <= '0;
                  ayy_ff <= '0;
                  mxy_ff <= NW'(ent_ff.sxy);
                  mxx_ff <= NW'(ent_ff.sxx);
                  myy_ff <= NW'(ent_ff.syy);
                  nsh_ff <= ent_ff.n;
                  state_ff <= NMUL;
               end
            end
            NMUL: begin
               // shift-add of the count into the three sums
               if (nsh_ff[0]) begin
                  axy_ff <= axy_ff + mxy_ff;
                  axx_ff <= axx_ff + mxx_ff;
                  ayy_ff <= ayy_ff + myy_ff;
               end
               mxy_ff <= mxy_ff <<< 1;
               mxx_ff <= mxx_ff <<< 1;
               myy_ff <= myy_ff <<< 1;
               nsh_ff <= nsh_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(pcc_pkg::CNT_BITS - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= VARS;
               end
            end
            VARS: begin
               num_ff <= num_c;
               ovf_ff <= ent_ff.ovf;
               if (vx_c[NW-1] || vx_c == '0 || vy_c[NW-1] || vy_c == '0) begin
                  zero_ff <= 1'b1;
                  corr_ff <= '0;
                  valid_ff <= 1'b1;
                  state_ff <= DONE;
               end else begin
                  acc_ff <= '0;
                  sh_ff <= PW'(unsigned'(vx_c));
                  b_ff <= unsigned'(vy_c);
                  state_ff <= VMUL;
               end
            end
            VMUL: begin
               if (b_ff[0]) acc_ff <= acc_ff + sh_ff;
               sh_ff <= sh_ff << 1;
               b_ff <= b_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(NW - 1)) begin
                  cnt_ff <= '0;
                  sh_ff <= b_ff[0] ? acc_ff + sh_ff : acc_ff;
                  rem_ff <= '0;
                  root_ff <= '0;
                  state_ff <= SQRT;
               end
            end
            SQRT: begin
               // two radicand bits per step, one root bit out
               sh_ff <= sh_ff << 2;
               if (r2 >= trial) begin
                  rem_ff <= r2 - trial;
                  root_ff <= {root_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= r2;
                  root_ff <= {root_ff[NW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(NW - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= DIVIDE;
                  rem_ff <= RW'(mag);
                  q_ff <= '0;
               end
            end
            DIVIDE: begin
               if (root_ff == '0) begin
                  zero_ff <= 1'b1;
                  corr_ff <= '0;
                  valid_ff <= 1'b1;
                  state_ff <= DONE;
               end else if (cnt_ff == '0 && mag >= root_ff) begin
                  // magnitude of one or more: clamp
                  zero_ff <= 1'b0;
                  corr_ff <= num_ff[NW-1] ? pcc_pkg::CORR_MIN : pcc_pkg::CORR_MAX;
                  valid_ff <= 1'b1;
                  state_ff <= DONE;
               end else begin
                  if (d2 >= RW'(root_ff)) begin
                     rem_ff <= d2 - RW'(root_ff);
                     q_ff <= {q_ff[pcc_pkg::FRAC_BITS-2:0], 1'b1};
                  end else begin
                     rem_ff <= d2;
                     q_ff <= {q_ff[pcc_pkg::FRAC_BITS-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CW'(pcc_pkg::FRAC_BITS)) begin
                     cnt_ff <= '0;
                     zero_ff <= 1'b0;
                     corr_ff <= num_ff[NW-1] ? -pcc_pkg::CORR_BITS'(q_ff)
                                             : pcc_pkg::CORR_BITS'(q_ff);
                     valid_ff <= 1'b1;
                     state_ff <= DONE;
                  end
               end
            end
            DONE: begin
               if (rsp.ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* tb/pcc_checker.sv */
// Checker for the Pearson correlation block: watches both channels,
// predicts each coefficient word and compares it. Depends on pcc_pkg, pcc_channels.
`timescale 1ns / 1ps
module pcc_checker #(
   parameter int MAX_SAMPLES = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   pcc_req_if.sink     req_mon,
   pcc_rsp_if.sink     rsp_mon,
   output int          fail_count,
   output int          pending,
   output int          vectors_seen
);
   typedef struct packed {
      logic signed [pcc_pkg::CORR_BITS-1:0] correlation;
      logic                                 zero_variance;
      logic                                 count_overflow;
   } coeff_type;

   coeff_type coeff_queue[$];

   int                                  acc_n;
   logic signed [pcc_pkg::LIN_BITS-1:0] acc_sx, acc_sy;
   logic signed [pcc_pkg::SQ_BITS-1:0]  acc_sxy, acc_sxx, acc_syy;
   logic                                acc_ovf;

   function automatic logic [52:0] root_of_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      logic [52:0]  r;
      logic [52:0]  c;
      p = a * b;
      r = '0;
      for (int i = 52; i >= 0; i--) begin
         c = r | (53'd1 << i);
         if ({75'd0, c} * {75'd0, c} <= p) r = c;
      end
      return r;
   endfunction

   function automatic coeff_type coefficient_of_sums();
      coeff_type   w;
      longint      n, num, vx, vy;
      logic [63:0] rt, a, rem, q;
      n  = longint'(acc_n);
      num = n * longint'(acc_sxy) - longint'(acc_sx) * longint'(acc_sy);
      vx  = n * longint'(acc_sxx) - longint'(acc_sx) * longint'(acc_sx);
      vy  = n * longint'(acc_syy) - longint'(acc_sy) * longint'(acc_sy);
      w = '0;
      w.count_overflow = acc_ovf;
      if (vx <= 0 || vy <= 0) begin
         w.zero_variance = 1'b1;
      end else begin
         rt = 64'(root_of_product(vx, vy));
         if (rt == 0) begin
            w.zero_variance = 1'b1;
         end else begin
            a = (num < 0) ? -num : num;
            if (a >= rt) begin
               w.correlation = (num < 0) ? pcc_pkg::CORR_MIN : pcc_pkg::CORR_MAX;
            end else begin
               rem = a;
               q = 0;
               for (int i = 0; i < pcc_pkg::FRAC_BITS; i++) begin
                  rem = rem << 1;
                  q = q << 1;
                  if (rem >= rt) begin
                     rem = rem - rt;
                     q[0] = 1'b1;
                  end
               end
               w.correlation = (num < 0) ? -q[15:0] : q[15:0];
            end
         end
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      vectors_seen = 0;
   end

   assign pending = coeff_queue.size();

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] xs, ys;
      longint   x, y;
      coeff_type got, want;
      if (reset) begin
         acc_n = 0; acc_sx = '0; acc_sy = '0;
         acc_sxy = '0; acc_sxx = '0; acc_syy = '0; acc_ovf = 1'b0;
         coeff_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            xs = SAMPLE_BITS'(unsigned'(req_mon.sample_x));
            ys = SAMPLE_BITS'(unsigned'(req_mon.sample_y));
            x = xs;
            y = ys;
            if (acc_n >= MAX_SAMPLES) begin
               acc_ovf = 1'b1;
            end else begin
               acc_n++;
               acc_sx  = acc_sx + x[pcc_pkg::LIN_BITS-1:0];
               acc_sy  = acc_sy + y[pcc_pkg::LIN_BITS-1:0];
               acc_sxy = acc_sxy + pcc_pkg::SQ_BITS'(x * y);
               acc_sxx = acc_sxx + pcc_pkg::SQ_BITS'(x * x);
               acc_syy = acc_syy + pcc_pkg::SQ_BITS'(y * y);
            end
            if (req_mon.last) begin
               coeff_queue.push_back(coefficient_of_sums());
               acc_n = 0; acc_sx = '0; acc_sy = '0;
               acc_sxy = '0; acc_sxx = '0; acc_syy = '0; acc_ovf = 1'b0;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            vectors_seen++;
            got.correlation    = rsp_mon.correlation;
            got.zero_variance  = rsp_mon.zero_variance;
            got.count_overflow = rsp_mon.count_overflow;
            if (coeff_queue.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = coeff_queue.pop_front();
               if (got.correlation !== want.correlation)
                  report_mismatch("correlation", got.correlation, want.correlation);
               if (got.zero_variance !== want.zero_variance)
                  report_mismatch("zero_variance", got.zero_variance, want.zero_variance);
               if (got.count_overflow !== want.count_overflow)
                  report_mismatch("count_overflow", got.count_overflow, want.count_overflow);
            end
         end
      end
   end
endmodule

/* tb/tb_pearson_correlation.sv */
// Top of the Pearson correlation testbench: clock, reset, stimulus, verdict.
// Depends on pcc_pkg, pcc_channels, pearson_correlation and pcc_checker.
`timescale 1ns / 1ps
module tb_pearson_correlation;
   localparam int MAX_N      = 256;
   localparam int RANDOM_PAIRS = 1400;
   localparam int STALL_LIMIT  = 20000;  // idle cycles before giving up
   localparam int BACK_END_LAT = 400;    // drain wait after the last word

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, vectors_seen;
   int   idle_cycles = 0;
   bit   stim_done = 1'b0;
   bit   long_hold = 1'b0;

   pcc_req_if req_chan ();
   pcc_rsp_if rsp_chan ();

   pearson_correlation #(.MAX_SAMPLES(MAX_N), .SAMPLE_BITS(16)) i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   pcc_checker #(.MAX_SAMPLES(MAX_N), .SAMPLE_BITS(16)) i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending(pending), .vectors_seen(vectors_seen)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.sample_x = '0;
      req_chan.sample_y = '0;
      req_chan.last     = 1'b0;
      rsp_chan.ready    = 1'b0;
   end

   // Offer one word after a random gap and hold it until the handshake.
   task automatic send_word(logic signed [15:0] x, logic signed [15:0] y, logic lst);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.sample_x <= x;
      req_chan.sample_y <= y;
      req_chan.last     <= lst;
      // look at ready mid-cycle, then take the accepting edge
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Send a vector of len pairs; kind picks how y relates to x.
   task automatic send_vector(int len, int kind);
      logic signed [15:0] x, y;
      for (int i = 0; i < len; i++) begin
         x = 16'($urandom);
         case (kind)
            0: y = 16'($urandom);
            1: y = x;
            2: y = -x;
            3: y = (x >>> 1) + $signed(16'($urandom_range(0, 255)) - 16'sd128);
            default: y = 16'sh0123;
         endcase
         send_word(x, y, i == len - 1);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off to fill the queue.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
         if (wait_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_chan.valid) @(negedge clock);
         @(posedge clock);
      end
   end

   // Watchdog: count cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("tb_pearson_correlation: done, errors");
         $finish;
      end
   end

   initial begin
      int sent, len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, single pair, constant data, full and past-full counts.
      send_word(16'sh7FFF, 16'sh8000, 1'b1);          // one pair: zero variance
      send_word(16'sh8000, 16'sh8000, 1'b0);
      send_word(16'sh7FFF, 16'sh7FFF, 1'b1);          // +1 saturates
      send_word(16'sh8000, 16'sh7FFF, 1'b0);
      send_word(16'sh7FFF, 16'sh8000, 1'b1);          // -1
      send_word(16'sh0005, 16'sh0001, 1'b0);
      send_word(16'sh0005, 16'sh0002, 1'b0);
      send_word(16'sh0005, 16'sh0003, 1'b1);          // constant x
      send_word(16'sh0000, 16'sh0000, 1'b0);
      send_word(16'sh0001, 16'shFFFF, 1'b0);
      send_word(16'sh0002, 16'sh0001, 1'b1);
      send_vector(3, 1);
      send_vector(4, 2);
      send_vector(MAX_N + 3, 0);                      // pairs past the count are dropped
      send_vector(MAX_N, 3);                          // exactly full

      // Hold off the receiver while vectors keep coming, filling the queue.
      long_hold = 1'b1;
      for (int k = 0; k < 8; k++) send_vector(2 + k % 3, k % 4);

      // Random vectors, mostly short.
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         case ($urandom_range(0, 9))
            0: len = 1;
            1: len = $urandom_range(MAX_N - 2, MAX_N + 4);
            default: len = $urandom_range(2, 12);
         endcase
         send_vector(len, $urandom_range(0, 4));
         sent += len;
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;

      while (pending != 0) @(posedge clock);
      repeat (BACK_END_LAT) @(posedge clock);

      $display("covered %0d coefficient words over extreme, constant, full and overflowed vectors",
               vectors_seen);
      if (fail_count == 0)
         $display("tb_pearson_correlation: done, clean");
      else
         $display("tb_pearson_correlation: done, errors");
      $finish;
   end
endmodule
